// ===== rtl/core/c6502_pkg.sv =====
// Package for the 6502 instruction core: payload types, sequencer steps, decode.
package c6502_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] read_data;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] bus_address;
    logic        bus_write;
    logic [7:0]  write_data;
    logic        retired;
    logic        halted_illegal;
    logic [7:0]  acc_view;
    logic [7:0]  x_view;
    logic [7:0]  y_view;
    logic [7:0]  status_view;
    logic [7:0]  stack_view;
    logic [15:0] pc_view;
  } out_beat_t;

  localparam logic [3:0] ST_OPC   = 4'd0;
  localparam logic [3:0] ST_LO    = 4'd1;
  localparam logic [3:0] ST_HI    = 4'd2;
  localparam logic [3:0] ST_PLO   = 4'd3;
  localparam logic [3:0] ST_PHI   = 4'd4;
  localparam logic [3:0] ST_DATA  = 4'd5;
  localparam logic [3:0] ST_WR    = 4'd6;
  localparam logic [3:0] ST_PUSHA = 4'd7;
  localparam logic [3:0] ST_PUSHB = 4'd8;
  localparam logic [3:0] ST_PUSHC = 4'd9;
  localparam logic [3:0] ST_PULLA = 4'd10;
  localparam logic [3:0] ST_PULLB = 4'd11;
  localparam logic [3:0] ST_PULLC = 4'd12;

  localparam logic [3:0] M_IMP  = 4'd0;
  localparam logic [3:0] M_IMM  = 4'd1;
  localparam logic [3:0] M_ZP   = 4'd2;
  localparam logic [3:0] M_ZPX  = 4'd3;
  localparam logic [3:0] M_ZPY  = 4'd4;
  localparam logic [3:0] M_ABS  = 4'd5;
  localparam logic [3:0] M_ABSX = 4'd6;
  localparam logic [3:0] M_ABSY = 4'd7;
  localparam logic [3:0] M_INDX = 4'd8;
  localparam logic [3:0] M_INDY = 4'd9;
  localparam logic [3:0] M_REL  = 4'd10;
  localparam logic [3:0] M_BAD  = 4'd11;

  localparam logic [5:0] O_ORA = 6'd0;
  localparam logic [5:0] O_AND = 6'd1;
  localparam logic [5:0] O_EOR = 6'd2;
  localparam logic [5:0] O_ADC = 6'd3;
  localparam logic [5:0] O_STA = 6'd4;
  localparam logic [5:0] O_LDA = 6'd5;
  localparam logic [5:0] O_CMP = 6'd6;
  localparam logic [5:0] O_SBC = 6'd7;
  localparam logic [5:0] O_ASL = 6'd8;
  localparam logic [5:0] O_ROL = 6'd9;
  localparam logic [5:0] O_LSR = 6'd10;
  localparam logic [5:0] O_ROR = 6'd11;
  localparam logic [5:0] O_STX = 6'd12;
  localparam logic [5:0] O_LDX = 6'd13;
  localparam logic [5:0] O_DEC = 6'd14;
  localparam logic [5:0] O_INC = 6'd15;
  localparam logic [5:0] O_BIT = 6'd16;
  localparam logic [5:0] O_JMP = 6'd17;
  localparam logic [5:0] O_JMI = 6'd18;
  localparam logic [5:0] O_STY = 6'd19;
  localparam logic [5:0] O_LDY = 6'd20;
  localparam logic [5:0] O_CPY = 6'd21;
  localparam logic [5:0] O_CPX = 6'd22;
  localparam logic [5:0] O_BR  = 6'd23;
  localparam logic [5:0] O_BRK = 6'd24;
  localparam logic [5:0] O_JSR = 6'd25;
  localparam logic [5:0] O_RTI = 6'd26;
  localparam logic [5:0] O_RTS = 6'd27;
  localparam logic [5:0] O_PHP = 6'd28;
  localparam logic [5:0] O_PLP = 6'd29;
  localparam logic [5:0] O_PHA = 6'd30;
  localparam logic [5:0] O_PLA = 6'd31;
  localparam logic [5:0] O_IMP = 6'd32;
  localparam logic [5:0] O_BAD = 6'd33;

  localparam logic [7:0] F_C = 8'h01;
  localparam logic [7:0] F_Z = 8'h02;
  localparam logic [7:0] F_I = 8'h04;
  localparam logic [7:0] F_D = 8'h08;
  localparam logic [7:0] F_V = 8'h40;
  localparam logic [7:0] F_N = 8'h80;

  typedef struct packed {
    logic [3:0] md;
    logic [5:0] op;
  } dec_t;

  function automatic logic [3:0] grp1_mode(input logic [2:0] b);
    logic [3:0] m;
    unique case (b)
      3'd0: m = M_INDX;
      3'd1: m = M_ZP;
      3'd2: m = M_IMM;
      3'd3: m = M_ABS;
      3'd4: m = M_INDY;
      3'd5: m = M_ZPX;
      3'd6: m = M_ABSY;
      default: m = M_ABSX;
    endcase
    return m;
  endfunction

  function automatic dec_t decode(input logic [7:0] opc);
    dec_t r;
    logic [2:0] aaa;
    logic [2:0] bbb;
    logic [1:0] cc;
    aaa = opc[7:5];
    bbb = opc[4:2];
    cc = opc[1:0];
    r.md = M_BAD;
    r.op = O_BAD;
    if (cc == 2'd1) begin
      if (opc != 8'h89) begin
        r.op = {3'd0, aaa};
        r.md = grp1_mode(bbb);
      end
    end else if (cc == 2'd2) begin
      r.op = O_ASL + {3'd0, aaa};
      unique case (bbb)
        3'd0: if (opc == 8'hA2) r.md = M_IMM;
        3'd1: r.md = M_ZP;
        3'd2: begin
          r.md = M_IMP;
          if (aaa >= 3'd4) r.op = O_IMP;
        end
        3'd3: r.md = M_ABS;
        3'd5: r.md = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
        3'd6: if (opc == 8'h9A || opc == 8'hBA) begin
          r.md = M_IMP;
          r.op = O_IMP;
        end
        3'd7: begin
          if (aaa == 3'd5) r.md = M_ABSY;
          else if (aaa != 3'd4) r.md = M_ABSX;
        end
        default: ;
      endcase
      if (r.md == M_BAD) r.op = O_BAD;
    end else if (cc == 2'd0) begin
      if (bbb == 3'd4) begin
        r.md = M_REL;
        r.op = O_BR;
      end else if (bbb == 3'd6) begin
        r.md = M_IMP;
        r.op = O_IMP;
      end else if (bbb == 3'd2) begin
        r.md = M_IMP;
        unique case (opc)
          8'h08: r.op = O_PHP;
          8'h28: r.op = O_PLP;
          8'h48: r.op = O_PHA;
          8'h68: r.op = O_PLA;
          default: r.op = O_IMP;
        endcase
      end else if (bbb == 3'd0) begin
        unique case (aaa)
          3'd0: begin r.md = M_IMP; r.op = O_BRK; end
          3'd1: begin r.md = M_ABS; r.op = O_JSR; end
          3'd2: begin r.md = M_IMP; r.op = O_RTI; end
          3'd3: begin r.md = M_IMP; r.op = O_RTS; end
          3'd4: ;
          default: begin r.md = M_IMM; r.op = 6'd15 + {3'd0, aaa}; end
        endcase
      end else if (aaa != 3'd0) begin
        if (bbb == 3'd1 && aaa != 3'd2 && aaa != 3'd3) r.md = M_ZP;
        else if (bbb == 3'd3) r.md = M_ABS;
        else if (bbb == 3'd5 && (aaa == 3'd4 || aaa == 3'd5)) r.md = M_ZPX;
        else if (bbb == 3'd7 && aaa == 3'd5) r.md = M_ABSX;
        if (r.md != M_BAD) r.op = 6'd15 + {3'd0, aaa};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cpu_6502_instruction_core.sv =====
// 6502 instruction core: one bus access per accepted beat.
//
// Usage: the input channel (in_valid / in_stall) carries one beat per bus
// access. func 0 restarts the core at the start address held in the
// configuration register (written through cfg_valid / cfg_ready, always
// ready); func 1 hands in the byte read by the previously issued access.
// Each accepted input beat yields exactly one output beat on the
// out_valid / out_stall channel: the next access address, write strobe and
// data, a retire flag, the halt flag and a view of the registers.
// out_valid rises in the cycle after acceptance. Throughput is one beat
// per cycle unless stalled; the sequencer step is a single combinational
// pass between the architectural registers and the output register. The
// block keeps accepting while the output register is empty or is being
// drained in the same cycle; a stalled result holds and stalls the input.
// Reset (rst_n low, synchronous) sets A, X, Y, PC and the latches to zero,
// S to 0xFF, status to 0x20, the start address to zero and empties the
// output register. The first func 1 beat after reset is taken as the
// opcode read at address zero.
module cpu_6502_instruction_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  c6502_pkg::in_beat_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output c6502_pkg::out_beat_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data
);

  logic [15:0] start_r;
  logic [7:0]  a_r, x_r, y_r, s_r, p_r, opc_r, opl_r;
  logic [15:0] pc_r, adl_r;
  logic [3:0]  st_r;
  logic        halt_r;
  logic        ov_r;
  c6502_pkg::out_beat_t ob_r;

  logic [7:0]  a_nxt, x_nxt, y_nxt, s_nxt, p_nxt, opc_nxt, opl_nxt;
  logic [15:0] pc_nxt, adl_nxt;
  logic [3:0]  st_nxt;
  logic        halt_nxt;
  logic [15:0] ba;
  logic        bw;
  logic [7:0]  bd;
  logic        done;

  logic accept;
  assign in_stall  = ov_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = ob_r;

  c6502_pkg::dec_t dl, dn;
  logic [7:0]  d;
  logic [8:0]  sum;
  logic [7:0]  av, mr;
  logic        mc;
  logic [15:0] t16;
  logic [7:0]  cmp_src;
  logic [8:0]  cdiff;
  logic        brt;
  logic [7:0]  bflag;

  assign d  = in_data.read_data;
  assign dl = c6502_pkg::decode(opc_r);

  always_comb begin
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; s_nxt = s_r; p_nxt = p_r;
    opc_nxt = opc_r; opl_nxt = opl_r; pc_nxt = pc_r; adl_nxt = adl_r;
    st_nxt = st_r; halt_nxt = halt_r;
    ba = pc_r; bw = 1'b0; bd = 8'h00; done = 1'b0;
    dn = c6502_pkg::decode(d);
    sum = 9'd0; av = 8'h00; mr = 8'h00; mc = 1'b0; t16 = 16'h0000;
    cmp_src = 8'h00; cdiff = 9'd0; brt = 1'b0; bflag = 8'h00;
    if (!in_data.func) begin
      a_nxt = 8'h00; x_nxt = 8'h00; y_nxt = 8'h00; s_nxt = 8'hFF; p_nxt = 8'h20;
      opc_nxt = 8'h00; adl_nxt = 16'h0000; opl_nxt = 8'h00; halt_nxt = 1'b0;
      pc_nxt = start_r; st_nxt = c6502_pkg::ST_OPC; ba = start_r;
    end else if (halt_r) begin
      ba = pc_r;
    end else begin
      // Operand for read ops and read-modify-write comes from the bus byte,
      // except accumulator-mode shifts which use A.
      unique case (st_r)
        c6502_pkg::ST_OPC: begin
          opc_nxt = d;
          pc_nxt = pc_r + 16'd1;
          ba = pc_nxt;
          if (dn.op == c6502_pkg::O_BAD) begin
            halt_nxt = 1'b1;
          end else if (dn.op == c6502_pkg::O_BRK || dn.md != c6502_pkg::M_IMP) begin
            st_nxt = c6502_pkg::ST_LO;
          end else if (dn.op == c6502_pkg::O_PHA || dn.op == c6502_pkg::O_PHP) begin
            st_nxt = c6502_pkg::ST_PUSHA;
            ba = {8'h01, s_r}; bw = 1'b1;
            bd = (dn.op == c6502_pkg::O_PHA) ? a_r : (p_r | 8'h30);
            s_nxt = s_r - 8'd1;
          end else if (dn.op == c6502_pkg::O_PLA || dn.op == c6502_pkg::O_PLP ||
                       dn.op == c6502_pkg::O_RTS || dn.op == c6502_pkg::O_RTI) begin
            st_nxt = c6502_pkg::ST_PULLA;
            s_nxt = s_r + 8'd1;
            ba = {8'h01, s_nxt};
          end else if (dn.op >= c6502_pkg::O_ASL && dn.op <= c6502_pkg::O_ROR) begin
            av = a_r;
            unique case (dn.op)
              c6502_pkg::O_ASL: begin mc = av[7]; mr = {av[6:0], 1'b0}; end
              c6502_pkg::O_ROL: begin mc = av[7]; mr = {av[6:0], p_r[0]}; end
              c6502_pkg::O_LSR: begin mc = av[0]; mr = {1'b0, av[7:1]}; end
              default:          begin mc = av[0]; mr = {p_r[0], av[7:1]}; end
            endcase
            a_nxt = mr;
            p_nxt = {mr[7], p_r[6:2], (mr == 8'h00), mc};
            st_nxt = c6502_pkg::ST_OPC; ba = pc_nxt; done = 1'b1;
          end else begin
            unique case (d)
              8'h18: p_nxt = p_r & ~c6502_pkg::F_C;
              8'h38: p_nxt = p_r | c6502_pkg::F_C;
              8'h58: p_nxt = p_r & ~c6502_pkg::F_I;
              8'h78: p_nxt = p_r | c6502_pkg::F_I;
              8'hB8: p_nxt = p_r & ~c6502_pkg::F_V;
              8'hD8: p_nxt = p_r & ~c6502_pkg::F_D;
              8'hF8: p_nxt = p_r | c6502_pkg::F_D;
              8'hAA: begin x_nxt = a_r; av = a_r; end
              8'h8A: begin a_nxt = x_r; av = x_r; end
              8'hA8: begin y_nxt = a_r; av = a_r; end
              8'h98: begin a_nxt = y_r; av = y_r; end
              8'hCA: begin x_nxt = x_r - 8'd1; av = x_nxt; end
              8'hE8: begin x_nxt = x_r + 8'd1; av = x_nxt; end
              8'h88: begin y_nxt = y_r - 8'd1; av = y_nxt; end
              8'hC8: begin y_nxt = y_r + 8'd1; av = y_nxt; end
              8'h9A: s_nxt = x_r;
              8'hBA: begin x_nxt = s_r; av = s_r; end
              default: ;
            endcase
            if (d == 8'hAA || d == 8'h8A || d == 8'hA8 || d == 8'h98 || d == 8'hCA ||
                d == 8'hE8 || d == 8'h88 || d == 8'hC8 || d == 8'hBA)
              p_nxt = {av[7], p_r[6:2], (av == 8'h00), p_r[0]};
            st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
          end
        end
        c6502_pkg::ST_LO: begin
          opl_nxt = d;
          pc_nxt = pc_r + 16'd1;
          ba = pc_nxt;
          if (dl.op == c6502_pkg::O_BRK) begin
            st_nxt = c6502_pkg::ST_PUSHA;
            ba = {8'h01, s_r}; bw = 1'b1; bd = pc_nxt[15:8]; s_nxt = s_r - 8'd1;
          end else begin
            unique case (dl.md)
              c6502_pkg::M_IMM: begin
                st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
              end
              c6502_pkg::M_REL: begin
                unique case (opc_r[7:6])
                  2'd0: bflag = c6502_pkg::F_N;
                  2'd1: bflag = c6502_pkg::F_V;
                  2'd2: bflag = c6502_pkg::F_C;
                  default: bflag = c6502_pkg::F_Z;
                endcase
                brt = (p_r & bflag) != 8'h00;
                if (brt == opc_r[5]) pc_nxt = pc_r + 16'd1 + {{8{d[7]}}, d};
                ba = pc_nxt;
                st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
              end
              c6502_pkg::M_ZP:  adl_nxt = {8'h00, d};
              c6502_pkg::M_ZPX: adl_nxt = {8'h00, d + x_r};
              c6502_pkg::M_ZPY: adl_nxt = {8'h00, d + y_r};
              c6502_pkg::M_INDX: begin
                adl_nxt = {8'h00, d + x_r}; st_nxt = c6502_pkg::ST_PLO; ba = adl_nxt;
              end
              c6502_pkg::M_INDY: begin
                adl_nxt = {8'h00, d}; st_nxt = c6502_pkg::ST_PLO; ba = adl_nxt;
              end
              default: st_nxt = c6502_pkg::ST_HI;
            endcase
            if (dl.md == c6502_pkg::M_ZP || dl.md == c6502_pkg::M_ZPX ||
                dl.md == c6502_pkg::M_ZPY) begin
              ba = adl_nxt;
              st_nxt = c6502_pkg::ST_DATA;
              if (dl.op == c6502_pkg::O_STA || dl.op == c6502_pkg::O_STX ||
                  dl.op == c6502_pkg::O_STY) begin
                opl_nxt = (dl.op == c6502_pkg::O_STA) ? a_r :
                          (dl.op == c6502_pkg::O_STX) ? x_r : y_r;
                st_nxt = c6502_pkg::ST_WR; bw = 1'b1; bd = opl_nxt;
              end
            end
          end
        end
        c6502_pkg::ST_HI: begin
          t16 = {d, opl_r};
          pc_nxt = pc_r + 16'd1;
          ba = pc_nxt;
          if (dl.op == c6502_pkg::O_JMP) begin
            pc_nxt = t16; ba = t16; st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
          end else if (dl.op == c6502_pkg::O_JMI) begin
            adl_nxt = t16; st_nxt = c6502_pkg::ST_PLO; ba = t16;
          end else if (dl.op == c6502_pkg::O_JSR) begin
            adl_nxt = t16; st_nxt = c6502_pkg::ST_PUSHA;
            ba = {8'h01, s_r}; bw = 1'b1; bd = pc_r[15:8]; s_nxt = s_r - 8'd1;
          end else begin
            if (dl.md == c6502_pkg::M_ABSX) adl_nxt = t16 + {8'h00, x_r};
            else if (dl.md == c6502_pkg::M_ABSY) adl_nxt = t16 + {8'h00, y_r};
            else adl_nxt = t16;
            ba = adl_nxt; st_nxt = c6502_pkg::ST_DATA;
            if (dl.op == c6502_pkg::O_STA || dl.op == c6502_pkg::O_STX ||
                dl.op == c6502_pkg::O_STY) begin
              opl_nxt = (dl.op == c6502_pkg::O_STA) ? a_r :
                        (dl.op == c6502_pkg::O_STX) ? x_r : y_r;
              st_nxt = c6502_pkg::ST_WR; bw = 1'b1; bd = opl_nxt;
            end
          end
        end
        c6502_pkg::ST_PLO: begin
          opl_nxt = d;
          if (dl.md == c6502_pkg::M_INDX || dl.md == c6502_pkg::M_INDY)
            adl_nxt = {8'h00, adl_r[7:0] + 8'd1};
          else if (dl.op == c6502_pkg::O_BRK) adl_nxt = 16'hFFFF;
          else adl_nxt = adl_r + 16'd1;
          st_nxt = c6502_pkg::ST_PHI; ba = adl_nxt;
        end
        c6502_pkg::ST_PHI: begin
          t16 = {d, opl_r};
          if (dl.md == c6502_pkg::M_INDX || dl.md == c6502_pkg::M_INDY) begin
            adl_nxt = (dl.md == c6502_pkg::M_INDY) ? t16 + {8'h00, y_r} : t16;
            ba = adl_nxt; st_nxt = c6502_pkg::ST_DATA;
            if (dl.op == c6502_pkg::O_STA || dl.op == c6502_pkg::O_STX ||
                dl.op == c6502_pkg::O_STY) begin
              opl_nxt = (dl.op == c6502_pkg::O_STA) ? a_r :
                        (dl.op == c6502_pkg::O_STX) ? x_r : y_r;
              st_nxt = c6502_pkg::ST_WR; bw = 1'b1; bd = opl_nxt;
            end
          end else begin
            pc_nxt = t16; ba = t16; st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
          end
        end
        c6502_pkg::ST_DATA: begin
          if ((dl.op >= c6502_pkg::O_ASL && dl.op <= c6502_pkg::O_ROR) ||
              dl.op == c6502_pkg::O_DEC || dl.op == c6502_pkg::O_INC) begin
            mc = p_r[0];
            unique case (dl.op)
              c6502_pkg::O_ASL: begin mc = d[7]; mr = {d[6:0], 1'b0}; end
              c6502_pkg::O_ROL: begin mc = d[7]; mr = {d[6:0], p_r[0]}; end
              c6502_pkg::O_LSR: begin mc = d[0]; mr = {1'b0, d[7:1]}; end
              c6502_pkg::O_ROR: begin mc = d[0]; mr = {p_r[0], d[7:1]}; end
              c6502_pkg::O_INC: mr = d + 8'd1;
              default:          mr = d - 8'd1;
            endcase
            p_nxt = {mr[7], p_r[6:2], (mr == 8'h00), mc};
            opl_nxt = mr;
            st_nxt = c6502_pkg::ST_WR; ba = adl_r; bw = 1'b1; bd = mr;
          end else begin
            st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
          end
        end
        c6502_pkg::ST_PUSHA: begin
          if (dl.op == c6502_pkg::O_JSR || dl.op == c6502_pkg::O_BRK) begin
            st_nxt = c6502_pkg::ST_PUSHB;
            ba = {8'h01, s_r}; bw = 1'b1; s_nxt = s_r - 8'd1;
            t16 = pc_r - 16'd1;
            bd = (dl.op == c6502_pkg::O_JSR) ? t16[7:0] : pc_r[7:0];
          end else begin
            st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
          end
        end
        c6502_pkg::ST_PUSHB: begin
          if (dl.op == c6502_pkg::O_BRK) begin
            st_nxt = c6502_pkg::ST_PUSHC;
            ba = {8'h01, s_r}; bw = 1'b1; bd = p_r | 8'h30; s_nxt = s_r - 8'd1;
          end else begin
            if (dl.op == c6502_pkg::O_JSR) pc_nxt = adl_r;
            ba = pc_nxt; st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
          end
        end
        c6502_pkg::ST_PUSHC: begin
          p_nxt = p_r | c6502_pkg::F_I;
          adl_nxt = 16'hFFFE; ba = 16'hFFFE; st_nxt = c6502_pkg::ST_PLO;
        end
        c6502_pkg::ST_PULLA: begin
          if (dl.op == c6502_pkg::O_PLA) begin
            a_nxt = d; p_nxt = {d[7], p_r[6:2], (d == 8'h00), p_r[0]};
            st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
          end else if (dl.op == c6502_pkg::O_RTS) begin
            opl_nxt = d; st_nxt = c6502_pkg::ST_PULLB;
            s_nxt = s_r + 8'd1; ba = {8'h01, s_nxt};
          end else begin
            p_nxt = (d & 8'hCF) | 8'h20;
            if (dl.op == c6502_pkg::O_RTI) begin
              st_nxt = c6502_pkg::ST_PULLB; s_nxt = s_r + 8'd1; ba = {8'h01, s_nxt};
            end else begin
              st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
            end
          end
        end
        c6502_pkg::ST_PULLB: begin
          if (dl.op == c6502_pkg::O_RTS) begin
            pc_nxt = {d, opl_r} + 16'd1; ba = pc_nxt;
            st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
          end else begin
            opl_nxt = d; st_nxt = c6502_pkg::ST_PULLC;
            s_nxt = s_r + 8'd1; ba = {8'h01, s_nxt};
          end
        end
        c6502_pkg::ST_PULLC: begin
          pc_nxt = {d, opl_r}; ba = pc_nxt;
          st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
        end
        c6502_pkg::ST_WR: begin
          st_nxt = c6502_pkg::ST_OPC; done = 1'b1;
        end
        default: st_nxt = c6502_pkg::ST_OPC;
      endcase

      // Read-type execution on immediate and data-read completions.
      if ((st_r == c6502_pkg::ST_LO && dl.md == c6502_pkg::M_IMM &&
           dl.op != c6502_pkg::O_BRK) ||
          (st_r == c6502_pkg::ST_DATA &&
           !((dl.op >= c6502_pkg::O_ASL && dl.op <= c6502_pkg::O_ROR) ||
             dl.op == c6502_pkg::O_DEC || dl.op == c6502_pkg::O_INC))) begin
        av = (dl.op == c6502_pkg::O_SBC) ? ~d : d;
        sum = {1'b0, a_r} + {1'b0, av} + {8'h00, p_r[0]};
        cmp_src = (dl.op == c6502_pkg::O_CPX) ? x_r :
                  (dl.op == c6502_pkg::O_CPY) ? y_r : a_r;
        cdiff = {1'b0, cmp_src} - {1'b0, d};
        unique case (dl.op)
          c6502_pkg::O_ORA: a_nxt = a_r | d;
          c6502_pkg::O_AND: a_nxt = a_r & d;
          c6502_pkg::O_EOR: a_nxt = a_r ^ d;
          c6502_pkg::O_LDA: a_nxt = d;
          c6502_pkg::O_LDX: x_nxt = d;
          c6502_pkg::O_LDY: y_nxt = d;
          c6502_pkg::O_ADC, c6502_pkg::O_SBC: a_nxt = sum[7:0];
          default: ;
        endcase
        unique case (dl.op)
          c6502_pkg::O_ORA, c6502_pkg::O_AND, c6502_pkg::O_EOR, c6502_pkg::O_LDA:
            p_nxt = {a_nxt[7], p_r[6:2], (a_nxt == 8'h00), p_r[0]};
          c6502_pkg::O_LDX, c6502_pkg::O_LDY:
            p_nxt = {d[7], p_r[6:2], (d == 8'h00), p_r[0]};
          c6502_pkg::O_ADC, c6502_pkg::O_SBC:
            p_nxt = {sum[7], ~(a_r[7] ^ av[7]) & (a_r[7] ^ sum[7]), p_r[5:2],
                     (sum[7:0] == 8'h00), sum[8]};
          c6502_pkg::O_CMP, c6502_pkg::O_CPX, c6502_pkg::O_CPY:
            p_nxt = {cdiff[7], p_r[6:2], (cdiff[7:0] == 8'h00), ~cdiff[8]};
          c6502_pkg::O_BIT:
            p_nxt = {d[7:6], p_r[5:2], ((d & a_r) == 8'h00), p_r[0]};
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 16'h0000;
      a_r <= 8'h00; x_r <= 8'h00; y_r <= 8'h00; s_r <= 8'hFF; p_r <= 8'h20;
      opc_r <= 8'h00; opl_r <= 8'h00; pc_r <= 16'h0000; adl_r <= 16'h0000;
      st_r <= c6502_pkg::ST_OPC; halt_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) start_r <= cfg_data;
      if (accept) begin
        a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; s_r <= s_nxt; p_r <= p_nxt;
        opc_r <= opc_nxt; opl_r <= opl_nxt; pc_r <= pc_nxt; adl_r <= adl_nxt;
        st_r <= st_nxt; halt_r <= halt_nxt;
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ob_r.bus_address    <= ba;
      ob_r.bus_write      <= bw;
      ob_r.write_data     <= bd;
      ob_r.retired        <= done;
      ob_r.halted_illegal <= halt_nxt;
      ob_r.acc_view       <= a_nxt;
      ob_r.x_view         <= x_nxt;
      ob_r.y_view         <= y_nxt;
      ob_r.status_view    <= p_nxt;
      ob_r.stack_view     <= s_nxt;
      ob_r.pc_view        <= pc_nxt;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(ob_r)))
    else $error("stalled result changed");
  a_status_bit5: assert property (@(posedge clk) disable iff (!rst_n)
    p_r[5] && !p_r[4])
    else $error("status bits 5/4 wrong");
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && halt_r && in_data.func) |=> ($stable(pc_r) && $stable(a_r) && halt_r))
    else $error("halted core changed state");
  a_write_in_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && st_r == c6502_pkg::ST_WR && in_data.func && !halt_r) |=> ob_r.retired)
    else $error("write step did not retire");

endmodule
